>>> rtl/sida_pkg.sv
package sida_pkg;

    // Value and text geometry
    localparam int MAG_W = 32;
    localparam int NDIG  = 10;
    localparam int DIG_W = 4;
    localparam int DIDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(MAG_W);

    // Configuration
    localparam int          CFG_W         = 5;
    localparam logic [CFG_W-1:0] MIN_WIDTH_RST = 5'd8;
    localparam logic        REG_MIN_WIDTH = 1'b0;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Classified item passed from front to back
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

endpackage

>>> rtl/sida_front.sv
module sida_front
    import sida_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    t_item      w_item;

    // Sign split and magnitude; the most negative value wraps to 2^31 unsigned
    always_comb begin
        w_item.neg = i_value[MAG_W-1];
        w_item.mag = w_item.neg ? (MAG_W'(0) - i_value) : i_value;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rptr];

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

>>> rtl/sida_back.sv
module sida_back
    import sida_pkg::*;
#(
    parameter int MAX_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_min_width,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_char_code,
    output logic             o_is_last
);

    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int BCD_W = NDIG * DIG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [MAG_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [WW-1:0]      r_pad;
    logic [DIDX_W-1:0]  r_didx;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [BCD_W-1:0]   w_adj;
    logic [DIDX_W:0]    w_ndig;
    logic [WW-1:0]      w_width;
    logic [WW-1:0]      w_textlen;
    logic               w_slot;
    logic [DIG_W-1:0]   w_digit;

    // Shift-add-3: bump every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[i*DIG_W +: DIG_W] = (r_bcd[i*DIG_W +: DIG_W] >= 4'd5)
                ? r_bcd[i*DIG_W +: DIG_W] + 4'd3 : r_bcd[i*DIG_W +: DIG_W];
        end
    end

    // Digit count: position of highest nonzero digit, at least one
    always_comb begin
        w_ndig = (DIDX_W + 1)'(1);
        for (int i = 1; i < NDIG; i++) begin
            if (r_bcd[i*DIG_W +: DIG_W] != '0) begin
                w_ndig = (DIDX_W + 1)'(i + 1);
            end
        end
    end

    // Effective field width and text length
    always_comb begin
        w_width   = (WW'(i_min_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(i_min_width);
        w_textlen = WW'(w_ndig) + WW'(r_neg);
    end

    assign w_slot      = !r_out_valid || !i_out_stall;
    assign w_digit     = r_bcd[r_didx*DIG_W +: DIG_W];
    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Outside emit a taken character leaves the output empty
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_bin   <= i_q_item.mag;
                        r_neg   <= i_q_item.neg;
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(MAG_W - 1);
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bcd <= {w_adj[BCD_W-2:0], r_bin[MAG_W-1]};
                    r_bin <= {r_bin[MAG_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    r_pad   <= (w_width > w_textlen) ? (w_width - w_textlen) : '0;
                    r_didx  <= DIDX_W'(w_ndig - (DIDX_W + 1)'(1));
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // One character per free output slot: pad, sign, digits
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_last      <= 1'b0;
                        priority if (r_pad != '0) begin
                            r_char <= CH_SPACE;
                            r_pad  <= r_pad - WW'(1);
                        end else if (r_neg) begin
                            r_char <= CH_MINUS;
                            r_neg  <= 1'b0;
                        end else begin
                            r_char <= CH_ZERO + 8'(w_digit);
                            r_didx <= r_didx - DIDX_W'(1);
                            if (r_didx == '0) begin
                                r_last  <= 1'b1;
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// From item accept to first character the back end passes through dequeue, 32 shift-add-3
// steps, width plan and output register; then one character per cycle while not stalled.
// The single shift-add-3 converter finishes one item's text before it dequeues the next;
// a two-entry queue lets the next item be taken meanwhile.
// Reset (synchronous, active low) empties the queue and output, min_width returns to 8.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int MAX_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_char_code,
    output logic        o_is_last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0] r_min_width;
    logic             w_q_valid;
    logic             w_q_pop;
    t_item            w_q_item;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_WIDTH) ? {{(32 - CFG_W){1'b0}}, r_min_width} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= MIN_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_WIDTH)) begin
            r_min_width <= pwdata[CFG_W-1:0];
        end
    end

    // Front: accept, classify, queue
    sida_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    // Back: convert and emit
    sida_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_width (r_min_width),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    // Back never dequeues from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("dequeue from empty queue");

    // Only space, minus or a decimal digit leaves the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_code == CH_SPACE || o_char_code == CH_MINUS ||
                         (o_char_code >= CH_ZERO && o_char_code <= CH_NINE)))
        else $error("illegal character code");

    // The last character of a text is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (o_char_code >= CH_ZERO && o_char_code <= CH_NINE))
        else $error("text ends on a non-digit");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

>>> tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii
    import sida_pkg::*;
();

    localparam int MAX_W = 16;
    localparam int REG_UNUSED = 1;
    localparam int N_STAGES = 9;
    localparam int RAND_PER_STAGE = 17;

    // One emitted character
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_char_code;
    logic        o_is_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] value_q[$];
    t_text_char  char_q[$];
    logic [4:0]  width_cfg = MIN_WIDTH_RST;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    signed_int_to_decimal_ascii #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_char_code(o_char_code),
        .o_is_last  (o_is_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // Expected text of one value: padding, sign, digits MS first
    function automatic void predict_text(input logic [31:0] v);
        logic       neg;
        logic [31:0] mag;
        logic [3:0] digs [0:10];
        int         nd;
        int         tlen;
        int         fw;
        neg = v[31];
        mag = neg ? (32'd0 - v) : v;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0);
        tlen = nd + (neg ? 1 : 0);
        fw = (int'(width_cfg) > MAX_W) ? MAX_W : int'(width_cfg);
        for (int i = tlen; i < fw; i++)
            char_q.push_back('{code: CH_SPACE, last: 1'b0});
        if (neg)
            char_q.push_back('{code: CH_MINUS, last: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            char_q.push_back('{code: CH_ZERO + 8'(digs[i]), last: (i == 0)});
    endfunction

    // Random value: full range, small, near powers of ten, near the extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: p = $urandom_range(0, 999);
            3: begin
                k = $urandom_range(0, 9);
                p = 32'd1;
                repeat (k) p = p * 32'd10;
                p = p - $urandom_range(0, 1);
            end
            default: p = 32'h8000_0000 - $urandom_range(0, 3);
        endcase
        return $urandom_range(0, 1) ? (32'd0 - p) : p;
    endfunction

    // Register write: setup then access phase
    task automatic cfg_write(input int idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_MIN_WIDTH))
            width_cfg = data[4:0];
    endtask

    // Wait until every item is taken and its text has come out
    task automatic wait_drained();
        while (n_accepted != n_queued || char_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_value(input logic [31:0] v);
        value_q.push_back(v);
        n_queued++;
    endtask

    // Input driver
    always @(posedge i_clk) begin : drive_proc
        logic send;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_text(i_value);
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                send = (value_q.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
                if (send)
                    i_value <= value_q.pop_front();
                i_in_valid <= send;
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge i_clk) begin : watch_proc
        t_text_char exp_c;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (char_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected char: code=%h last=%b", o_char_code, o_is_last);
                end else begin
                    exp_c = char_q.pop_front();
                    if (o_char_code !== exp_c.code || o_is_last !== exp_c.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("char mismatch: exp code=%h last=%b, got code=%h last=%b",
                                     exp_c.code, exp_c.last, o_char_code, o_is_last);
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Stimulus sequence
    initial begin : stim_proc
        logic [4:0] widths [1:N_STAGES-1];
        widths = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd11, 5'd12, 5'd3};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int s = 0; s < N_STAGES; s++) begin
            // idle mix: sender light/receiver heavy, then swapped, then none
            if (s < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 52;
            end else if (s < 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (s == 0) begin
                // reset width, directed corners
                @(negedge i_clk);
            end else begin
                if (s == 1)
                    cfg_write(REG_UNUSED, 32'd5);
                cfg_write(int'(REG_MIN_WIDTH), {27'($urandom), widths[s]});
                @(negedge i_clk);
                repeat (RAND_PER_STAGE) queue_value(pick_value());
            end
            if (s == 0) begin
                queue_value(32'd0);
                queue_value(32'd1);
                queue_value(32'hFFFF_FFFF);
                queue_value(32'd9);
                queue_value(32'd10);
                queue_value(-32'sd10);
                queue_value(32'd99);
                queue_value(32'h7FFF_FFFF);
                queue_value(32'h8000_0000);
                queue_value(32'h8000_0001);
                queue_value(32'd1000000000);
                queue_value(-32'sd1000000000);
                queue_value(32'd999999999);
                queue_value(32'd12345678);
                queue_value(-32'sd12345678);
                queue_value(32'd100);
                queue_value(32'd7);
                queue_value(-32'sd5);
            end
            // sender holds off until all text is out
            wait_drained();
        end
        repeat (50) @(posedge i_clk);
        if (char_q.size() != 0)
            n_errors++;
        if (n_errors == 0) begin
            $display("tb_signed_int_to_decimal_ascii passed");
        end else begin
            $display("tb_signed_int_to_decimal_ascii failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("tb_signed_int_to_decimal_ascii failed");
        $finish;
    end

endmodule
